// File: sv/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg
// shared constants, codes and the line access function of the two-way cache
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int SET_BITS      = 5;
  localparam int OFF_BITS      = 4;
  localparam int ADDRESS_WIDTH = 24;
  localparam int TAG_BITS      = ADDRESS_WIDTH - SET_BITS - OFF_BITS;
  localparam int NUM_SETS      = 1 << SET_BITS;
  localparam int NUM_LINES     = 2 * NUM_SETS;
  localparam int LINE_BYTES    = 1 << OFF_BITS;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;
  localparam logic [1:0] FUNC_INVAL = 2'd3;

  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_WB   = 2'd1;
  localparam logic [1:0] KIND_FREQ = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLIP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef logic [8*LINE_BYTES-1:0] line_t;

  typedef struct packed {
    line_t       line;
    logic [63:0] rdata;
    logic [1:0]  status;
  } acc_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [ADDRESS_WIDTH-1:0] mem_addr;
    logic [63:0]              data;
    logic                     hit;
    logic [1:0]               status;
    logic [31:0]              hit_count;
    logic [31:0]              miss_count;
    logic                     last;
  } rsp_t;

  // byte access of 0 to 8 bytes inside one line, clipped at the line end
  function automatic acc_t line_access(line_t line, logic [OFF_BITS-1:0] off,
                                       logic write, logic [3:0] size,
                                       logic [63:0] wdata);
    logic [OFF_BITS:0]   n;
    logic [OFF_BITS:0]   offx;
    logic [LINE_BYTES-1:0] bmask;
    line_t               wsh;
    line_t               rsh;
    acc_t                a;
    offx = {1'b0, off};
    n = (size > 4'd8) ? (OFF_BITS+1)'(8) : (OFF_BITS+1)'(size);
    a.status = ST_OK;
    if (offx + n > (OFF_BITS+1)'(LINE_BYTES)) begin
      n = (OFF_BITS+1)'(LINE_BYTES) - offx;
      a.status = ST_CLIP;
    end
    for (int i = 0; i < LINE_BYTES; i++) begin
      bmask[i] = ((OFF_BITS+1)'(i) >= offx) && ((OFF_BITS+1)'(i) < offx + n);
    end
    wsh = line_t'(wdata) << {off, 3'b000};
    rsh = line >> {off, 3'b000};
    a.line = line;
    a.rdata = '0;
    for (int i = 0; i < LINE_BYTES; i++) begin
      if (bmask[i] && write) a.line[8*i +: 8] = wsh[8*i +: 8];
    end
    for (int j = 0; j < 8; j++) begin
      if ((OFF_BITS+1)'(j) < n) a.rdata[8*j +: 8] = rsh[8*j +: 8];
    end
    return a;
  endfunction

endpackage

// File: sv/twc_if.sv
// ----------------------------------------------------------------------------
// twc request and response channels
// valid/ready channels carrying cache requests and cache results
// ----------------------------------------------------------------------------
interface twc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [23:0] addr;
  logic [3:0]  size;
  logic [63:0] wdata;
  logic [63:0] fill_data;
  modport source (output valid, func, addr, size, wdata, fill_data, input ready);
  modport sink (input valid, func, addr, size, wdata, fill_data, output ready);
endinterface

interface twc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] mem_addr;
  logic [63:0] data;
  logic        hit;
  logic [1:0]  status;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic        last;
  modport source (output valid, kind, mem_addr, data, hit, status, hit_count,
                  miss_count, last, input ready);
  modport sink (input valid, kind, mem_addr, data, hit, status, hit_count,
                miss_count, last, output ready);
endinterface

// File: sv/two_way_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// two_way_writeback_cache_core
// two-way set-associative write-back cache, 32 sets of 16-byte lines
// ----------------------------------------------------------------------------
// One transaction at a time. A hit is accepted, then the registered tag and
// data RAM read is checked and, for a write, the line is written back. A miss
// gives its results one after another (a dirty victim adds its two writeback
// beats ahead of the fill request). A fill beat that does not finish the line
// gives no result; the last one goes on to complete the access, as the other
// line word comes back from the data RAM. Results sit in an output register;
// the block waits while it is full and not taken. Invalidate and rejected
// transactions are answered on accept. After reset the block is ready at
// once.
module two_way_writeback_cache_core (
  input  logic clk,
  input  logic rst,
  twc_req_if.sink   req,
  twc_rsp_if.source rsp
);
  import twc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOOKUP, S_WB1, S_FREQ, S_COMPLETE} state_t;

  state_t state;

  // data banks: index is {way, word}
  logic [63:0]         data_mem [4][NUM_SETS];
  logic [TAG_BITS-1:0] tag_mem  [2][NUM_SETS];
  logic [63:0]         rd_data  [4];
  logic [TAG_BITS-1:0] rd_tag   [2];

  logic [NUM_LINES-1:0]     valid_bits;
  logic [NUM_LINES-1:0]     dirty_bits;
  logic [NUM_SETS-1:0]      way0_victim;
  logic [31:0]              hit_total;
  logic [31:0]              miss_total;
  logic                     fill_pending;
  logic                     pend_write;
  logic                     pend_way;
  logic [ADDRESS_WIDTH-1:0] pend_addr;
  logic [3:0]               pend_size;
  logic [63:0]              pend_bytes;
  logic                     beat_idx;
  logic [63:0]              fill_reg;

  logic                     cur_write;
  logic [ADDRESS_WIDTH-1:0] cur_addr;
  logic [3:0]               cur_size;
  logic [63:0]              cur_wdata;

  logic                 out_valid;
  logic                 out_load;
  rsp_t                 out_reg;

  logic accept, slot_free;
  logic [SET_BITS-1:0] rd_set, acc_set, pend_set, dw_set;
  logic [TAG_BITS-1:0] acc_tag;
  logic hit0, hit1, is_hit, hway, victim;
  acc_t acc_lk, acc_cp;
  logic [3:0]  dwe;
  logic [63:0] dw_lo, dw_hi;
  logic        twe;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;

  assign acc_set  = cur_addr[OFF_BITS +: SET_BITS];
  assign acc_tag  = cur_addr[ADDRESS_WIDTH-1 -: TAG_BITS];
  assign pend_set = pend_addr[OFF_BITS +: SET_BITS];
  assign rd_set   = (req.func == FUNC_FILL) ? pend_set : req.addr[OFF_BITS +: SET_BITS];

  assign hit0   = valid_bits[{acc_set, 1'b0}] && (rd_tag[0] == acc_tag);
  assign hit1   = valid_bits[{acc_set, 1'b1}] && (rd_tag[1] == acc_tag);
  assign is_hit = hit0 || hit1;
  assign hway   = !hit0;
  assign victim = !way0_victim[acc_set];

  assign acc_lk = line_access(hway ? {rd_data[3], rd_data[2]} : {rd_data[1], rd_data[0]},
                              cur_addr[OFF_BITS-1:0], cur_write, cur_size, cur_wdata);
  assign acc_cp = line_access({fill_reg, pend_way ? rd_data[2] : rd_data[0]},
                              pend_addr[OFF_BITS-1:0], pend_write, pend_size, pend_bytes);

  // a result is loaded into the output register this cycle
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.func)
            FUNC_INVAL: out_load = 1'b1;
            FUNC_FILL:  out_load = !fill_pending;
            default:    out_load = fill_pending;
          endcase
        end
      end
      S_LOOKUP, S_WB1, S_FREQ, S_COMPLETE: out_load = slot_free;
      default: out_load = 1'b0;
    endcase
  end

  // ram write port
  always_comb begin
    dwe    = '0;
    dw_set = pend_set;
    dw_lo  = req.fill_data;
    dw_hi  = req.fill_data;
    twe    = 1'b0;
    if (accept && req.func == FUNC_FILL && fill_pending) begin
      dwe[{pend_way, beat_idx}] = 1'b1;
      twe = beat_idx;
    end else if (state == S_LOOKUP && slot_free && is_hit && cur_write) begin
      dw_set = acc_set;
      dw_lo  = acc_lk.line[63:0];
      dw_hi  = acc_lk.line[127:64];
      dwe[{hway, 1'b0}] = 1'b1;
      dwe[{hway, 1'b1}] = 1'b1;
    end else if (state == S_COMPLETE && slot_free && pend_write) begin
      dw_lo = acc_cp.line[63:0];
      dw_hi = acc_cp.line[127:64];
      dwe[{pend_way, 1'b0}] = 1'b1;
      dwe[{pend_way, 1'b1}] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (dwe[b]) data_mem[b][dw_set] <= b[0] ? dw_hi : dw_lo;
      if (accept) rd_data[b] <= data_mem[b][rd_set];
    end
    for (int w = 0; w < 2; w++) begin
      if (twe && pend_way == w[0])
        tag_mem[w][pend_set] <= pend_addr[ADDRESS_WIDTH-1 -: TAG_BITS];
      if (accept) rd_tag[w] <= tag_mem[w][rd_set];
    end
  end

  function automatic rsp_t mk(logic [1:0] kind, logic [ADDRESS_WIDTH-1:0] maddr,
                              logic [63:0] data, logic hit, logic [1:0] status,
                              logic [31:0] hc, logic [31:0] mc, logic last);
    rsp_t r;
    r.kind = kind; r.mem_addr = maddr; r.data = data; r.hit = hit;
    r.status = status; r.hit_count = hc; r.miss_count = mc; r.last = last;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      valid_bits   <= '0;
      dirty_bits   <= '0;
      way0_victim  <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      fill_pending <= 1'b0;
      pend_write   <= 1'b0;
      pend_way     <= 1'b0;
      pend_addr    <= '0;
      pend_size    <= '0;
      pend_bytes   <= '0;
      beat_idx     <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_write <= (req.func == FUNC_WRITE);
            cur_addr  <= req.addr;
            cur_size  <= req.size;
            cur_wdata <= req.wdata;
            unique case (req.func)
              FUNC_INVAL: begin
                valid_bits   <= '0;
                dirty_bits   <= '0;
                way0_victim  <= '0;
                fill_pending <= 1'b0;
                beat_idx     <= 1'b0;
                out_reg <= mk(KIND_RESP, '0, '0, 1'b0, ST_OK, hit_total, miss_total, 1'b1);
              end
              FUNC_FILL: begin
                if (!fill_pending) begin
                  out_reg <= mk(KIND_RESP, '0, '0, 1'b0, ST_REJECT, hit_total,
                                miss_total, 1'b1);
                end else if (!beat_idx) begin
                  beat_idx <= 1'b1;
                end else begin
                  beat_idx     <= 1'b0;
                  fill_pending <= 1'b0;
                  valid_bits[{pend_set, pend_way}] <= 1'b1;
                  dirty_bits[{pend_set, pend_way}] <= 1'b0;
                  fill_reg     <= req.fill_data;
                  state        <= S_COMPLETE;
                end
              end
              default: begin
                if (fill_pending) begin
                  out_reg <= mk(KIND_RESP, '0, '0, 1'b0, ST_REJECT, hit_total,
                                miss_total, 1'b1);
                end else begin
                  state <= S_LOOKUP;
                end
              end
            endcase
          end
        end
        S_LOOKUP: begin
          if (slot_free) begin
            if (is_hit) begin
              hit_total <= hit_total + 32'd1;
              way0_victim[acc_set] <= hway;
              if (cur_write) dirty_bits[{acc_set, hway}] <= 1'b1;
              out_reg <= mk(KIND_RESP, '0, cur_write ? 64'd0 : acc_lk.rdata, 1'b1,
                            acc_lk.status, hit_total + 32'd1, miss_total, 1'b1);
              state <= S_IDLE;
            end else begin
              miss_total <= miss_total + 32'd1;
              way0_victim[acc_set] <= victim;
              valid_bits[{acc_set, victim}] <= 1'b0;
              dirty_bits[{acc_set, victim}] <= 1'b0;
              fill_pending <= 1'b1;
              pend_write   <= cur_write;
              pend_way     <= victim;
              pend_addr    <= cur_addr;
              pend_size    <= (cur_size > 4'd8) ? 4'd8 : cur_size;
              pend_bytes   <= cur_wdata;
              beat_idx     <= 1'b0;
              if (valid_bits[{acc_set, victim}] && dirty_bits[{acc_set, victim}]) begin
                out_reg <= mk(KIND_WB, {rd_tag[victim], acc_set, OFF_BITS'(0)},
                              rd_data[{victim, 1'b0}], 1'b0, ST_OK, hit_total,
                              miss_total + 32'd1, 1'b0);
                state <= S_WB1;
              end else begin
                out_reg <= mk(KIND_FREQ, {cur_addr[ADDRESS_WIDTH-1:OFF_BITS], OFF_BITS'(0)},
                              '0, 1'b0, ST_OK, hit_total, miss_total + 32'd1, 1'b1);
                state <= S_IDLE;
              end
            end
          end
        end
        S_WB1: begin
          if (slot_free) begin
            out_reg <= mk(KIND_WB, {rd_tag[pend_way], pend_set, OFF_BITS'(0)},
                          rd_data[{pend_way, 1'b1}], 1'b0, ST_OK, hit_total,
                          miss_total, 1'b0);
            state <= S_FREQ;
          end
        end
        S_FREQ: begin
          if (slot_free) begin
            out_reg <= mk(KIND_FREQ, {pend_addr[ADDRESS_WIDTH-1:OFF_BITS], OFF_BITS'(0)},
                          '0, 1'b0, ST_OK, hit_total, miss_total, 1'b1);
            state <= S_IDLE;
          end
        end
        S_COMPLETE: begin
          if (slot_free) begin
            if (pend_write) dirty_bits[{pend_set, pend_way}] <= 1'b1;
            out_reg <= mk(KIND_RESP, '0, pend_write ? 64'd0 : acc_cp.rdata, 1'b0,
                          acc_cp.status, hit_total, miss_total, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_reg.kind;
  assign rsp.mem_addr   = out_reg.mem_addr;
  assign rsp.data       = out_reg.data;
  assign rsp.hit        = out_reg.hit;
  assign rsp.status     = out_reg.status;
  assign rsp.hit_count  = out_reg.hit_count;
  assign rsp.miss_count = out_reg.miss_count;
  assign rsp.last       = out_reg.last;

  a_inval_resp: assert property (@(posedge clk) disable iff (rst)
    accept && req.func == FUNC_INVAL |=> rsp.valid && rsp.last && rsp.status == ST_OK)
    else $error("invalidate not answered");

  a_wb_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_WB1 || state == S_FREQ |-> fill_pending)
    else $error("writeback without pending fill");

  a_wb_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.kind == KIND_WB |-> !out_reg.last)
    else $error("writeback beat marked last");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the two-way cache with directed and random accesses, fill beats and
// invalidates, and checks every result against a cache predictor
// ----------------------------------------------------------------------------
module tb_top;
  import twc_pkg::*;

  logic clk;
  logic rst;

  twc_req_if req ();
  twc_rsp_if rsp ();

  two_way_writeback_cache_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // predictor state
  logic [63:0]         cache_words [NUM_LINES*2];
  logic [TAG_BITS-1:0] cache_tag [NUM_LINES];
  logic                cache_valid [NUM_LINES];
  logic                cache_dirty [NUM_LINES];
  logic                way0_victim [NUM_SETS];
  logic [31:0]         hits;
  logic [31:0]         misses;
  logic                fill_busy;
  logic                fill_wr;
  logic                fill_way;
  logic [23:0]         fill_addr;
  logic [3:0]          fill_size;
  logic [63:0]         fill_wdata;
  logic                fill_beat;

  rsp_t expected_q[$];
  int   n_fail;
  int   n_items;
  int   n_results;
  int   n_miss_seen;

  // directed rows; chk set means the predicted kind and status of the last result must match the typed-in ones
  typedef struct {
    logic [1:0]  func;
    logic [23:0] addr;
    logic [3:0]  size;
    logic [63:0] wdata;
    logic [63:0] fill;
    logic        chk;
    logic [1:0]  ekind;
    logic [1:0]  estatus;
  } row_t;

  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("Verification failed");
    $finish;
  end

  function automatic rsp_t mk(logic [1:0] kind, logic [23:0] maddr, logic [63:0] d,
                              logic h, logic [1:0] st);
    rsp_t r;
    r.kind = kind;
    r.mem_addr = maddr;
    r.data = d;
    r.hit = h;
    r.status = st;
    r.hit_count = hits;
    r.miss_count = misses;
    r.last = 1'b0;
    return r;
  endfunction

  // byte access on one line of the predictor, returns read data
  task automatic touch_line(input int ln, input logic [23:0] a, input logic wr,
                            input logic [3:0] sz, input logic [63:0] wd,
                            output logic [63:0] rd, output logic [1:0] st);
    int off;
    int n;
    int b;
    off = a[OFF_BITS-1:0];
    n = (sz > 8) ? 8 : sz;
    st = ST_OK;
    rd = '0;
    if (off + n > LINE_BYTES) begin
      n = LINE_BYTES - off;
      st = ST_CLIP;
    end
    for (int i = 0; i < n; i++) begin
      b = off + i;
      if (wr) cache_words[ln*2 + b/8][8*(b%8) +: 8] = wd[8*i +: 8];
      else rd[8*i +: 8] = cache_words[ln*2 + b/8][8*(b%8) +: 8];
    end
    if (wr) cache_dirty[ln] = 1'b1;
  endtask

  task automatic predict_cache(input logic [1:0] f, input logic [23:0] a,
                               input logic [3:0] sz, input logic [63:0] wd,
                               input logic [63:0] fd);
    rsp_t out[$];
    logic [63:0] rd;
    logic [1:0] st;
    int set_i;
    int ln;
    int way;
    int v;
    logic [TAG_BITS-1:0] tg;
    if (f == FUNC_INVAL) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        cache_valid[i] = 1'b0;
        cache_dirty[i] = 1'b0;
      end
      for (int i = 0; i < NUM_SETS; i++) way0_victim[i] = 1'b0;
      fill_busy = 1'b0;
      fill_beat = 1'b0;
      out.push_back(mk(KIND_RESP, '0, '0, 1'b0, ST_OK));
    end else if (f == FUNC_FILL) begin
      if (!fill_busy) begin
        out.push_back(mk(KIND_RESP, '0, '0, 1'b0, ST_REJECT));
      end else begin
        set_i = fill_addr[OFF_BITS +: SET_BITS];
        ln = set_i*2 + fill_way;
        cache_words[ln*2 + fill_beat] = fd;
        if (!fill_beat) begin
          fill_beat = 1'b1;
        end else begin
          fill_beat = 1'b0;
          fill_busy = 1'b0;
          cache_tag[ln] = fill_addr[23 -: TAG_BITS];
          cache_valid[ln] = 1'b1;
          cache_dirty[ln] = 1'b0;
          touch_line(ln, fill_addr, fill_wr, fill_size, fill_wdata, rd, st);
          out.push_back(mk(KIND_RESP, '0, fill_wr ? 64'd0 : rd, 1'b0, st));
        end
      end
    end else if (fill_busy) begin
      out.push_back(mk(KIND_RESP, '0, '0, 1'b0, ST_REJECT));
    end else begin
      set_i = a[OFF_BITS +: SET_BITS];
      tg = a[23 -: TAG_BITS];
      way = -1;
      if (cache_valid[set_i*2] && cache_tag[set_i*2] == tg) way = 0;
      else if (cache_valid[set_i*2+1] && cache_tag[set_i*2+1] == tg) way = 1;
      if (way >= 0) begin
        hits++;
        way0_victim[set_i] = (way == 1);
        touch_line(set_i*2 + way, a, f == FUNC_WRITE, sz, wd, rd, st);
        out.push_back(mk(KIND_RESP, '0, (f == FUNC_WRITE) ? 64'd0 : rd, 1'b1, st));
      end else begin
        misses++;
        v = way0_victim[set_i] ? 0 : 1;
        way0_victim[set_i] = (v == 1);
        ln = set_i*2 + v;
        if (cache_valid[ln] && cache_dirty[ln]) begin
          for (int w = 0; w < 2; w++)
            out.push_back(mk(KIND_WB, {cache_tag[ln], 5'(set_i), 4'd0},
                             cache_words[ln*2 + w], 1'b0, ST_OK));
        end
        cache_valid[ln] = 1'b0;
        cache_dirty[ln] = 1'b0;
        fill_busy = 1'b1;
        fill_wr = (f == FUNC_WRITE);
        fill_way = v[0];
        fill_addr = a;
        fill_size = (sz > 8) ? 4'd8 : sz;
        fill_wdata = wd;
        fill_beat = 1'b0;
        out.push_back(mk(KIND_FREQ, {a[23:4], 4'd0}, '0, 1'b0, ST_OK));
      end
    end
    if (out.size() > 0) out[out.size()-1].last = 1'b1;
    foreach (out[i]) expected_q.push_back(out[i]);
  endtask

  // request driver; valid stays high into the next transaction when there is no gap
  task automatic send_req(input logic [1:0] f, input logic [23:0] a,
                          input logic [3:0] sz, input logic [63:0] wd,
                          input logic [63:0] fd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.addr <= a;
    req.size <= sz;
    req.wdata <= wd;
    req.fill_data <= fd;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_cache(f, a, sz, wd, fd);
    n_items++;
  endtask

  // response side: random stalls and checking
  initial begin
    int stall;
    rsp_t e;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("unexpected result kind %0d", rsp.kind);
          n_fail++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.kind == KIND_FREQ) n_miss_seen++;
          if (rsp.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, rsp.kind); n_fail++;
          end
          if (rsp.mem_addr !== e.mem_addr) begin
            $error("mem_addr exp %h got %h", e.mem_addr, rsp.mem_addr); n_fail++;
          end
          if (rsp.data !== e.data) begin
            $error("data exp %h got %h", e.data, rsp.data); n_fail++;
          end
          if (rsp.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, rsp.hit); n_fail++;
          end
          if (rsp.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp.status); n_fail++;
          end
          if (rsp.hit_count !== e.hit_count) begin
            $error("hit_count exp %0d got %0d", e.hit_count, rsp.hit_count); n_fail++;
          end
          if (rsp.miss_count !== e.miss_count) begin
            $error("miss_count exp %0d got %0d", e.miss_count, rsp.miss_count);
            n_fail++;
          end
          if (rsp.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, rsp.last); n_fail++;
          end
        end
      end
      if (!rsp.ready || (rsp.valid && rsp.ready)) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (stall == 0) rsp.ready <= 1'b1;
        else begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  function automatic row_t mkrow(logic [1:0] f, logic [23:0] a, logic [3:0] sz,
                                 logic [63:0] wd, logic [63:0] fd, logic chk,
                                 logic [1:0] ek, logic [1:0] es);
    row_t r;
    r.func = f; r.addr = a; r.size = sz; r.wdata = wd; r.fill = fd;
    r.chk = chk; r.ekind = ek; r.estatus = es;
    return r;
  endfunction

  // access, then two fill beats if it missed, random content
  task automatic access_line(input logic [1:0] f, input logic [23:0] a,
                             input logic [3:0] sz);
    send_req(f, a, sz, {$urandom, $urandom}, {$urandom, $urandom});
    if (fill_busy) begin
      send_req(FUNC_FILL, 24'($urandom), 4'($urandom), {$urandom, $urandom},
               {$urandom, $urandom});
      send_req(FUNC_FILL, 24'($urandom), 4'($urandom), {$urandom, $urandom},
               {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [23:0] hot [8];
    logic [1:0] f;
    int sel;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_READ;
    req.addr = '0;
    req.size = '0;
    req.wdata = '0;
    req.fill_data = '0;
    n_fail = 0; n_items = 0; n_results = 0; n_miss_seen = 0;
    hits = '0; misses = '0;
    fill_busy = 0; fill_wr = 0; fill_way = 0; fill_addr = '0;
    fill_size = '0; fill_wdata = '0; fill_beat = 0;
    for (int i = 0; i < NUM_LINES; i++) begin
      cache_valid[i] = 0; cache_dirty[i] = 0; cache_tag[i] = '0;
    end
    for (int i = 0; i < NUM_SETS; i++) way0_victim[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill with nothing pending, extremes, clipping, sizes 0 and 15,
    // access during fill, dirty victim writeback, invalidate mid-fill
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd1, '0, '1, 1, KIND_RESP, ST_REJECT));
    rows.push_back(mkrow(FUNC_WRITE, 24'hFFFFFF, 4'd8, '1, '0, 1, KIND_FREQ, ST_OK));
    rows.push_back(mkrow(FUNC_READ, 24'h000010, 4'd1, '0, '0, 1, KIND_RESP, ST_REJECT));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, 64'h0123456789ABCDEF, 0, 0, 0));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, '1, 0, 0, 0));
    rows.push_back(mkrow(FUNC_READ, 24'hFFFFF8, 4'd15, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_WRITE, 24'hFFFFF3, 4'd0, '1, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_READ, 24'hFFFFF0, 4'd8, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_READ, 24'h0001F0, 4'd8, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, 64'h5555AAAA5555AAAA, 0, 0, 0));
    rows.push_back(mkrow(FUNC_READ, 24'h7001F4, 4'd3, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, '1, 0, 0, 0));
    rows.push_back(mkrow(FUNC_FILL, 24'h0, 4'd0, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_READ, 24'h0001F9, 4'd8, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_WRITE, 24'h1231F0, 4'd4, 64'hDEADBEEF, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_INVAL, 24'h0, 4'd0, '0, '0, 1, KIND_RESP, ST_OK));
    rows.push_back(mkrow(FUNC_READ, 24'hFFFFF0, 4'd8, '0, '0, 0, 0, 0));
    rows.push_back(mkrow(FUNC_INVAL, 24'h0, 4'd0, '0, '0, 1, KIND_RESP, ST_OK));
    foreach (rows[i]) begin
      send_req(rows[i].func, rows[i].addr, rows[i].size, rows[i].wdata, rows[i].fill);
      if (rows[i].chk) begin
        if (expected_q[expected_q.size()-1].kind !== rows[i].ekind ||
            expected_q[expected_q.size()-1].status !== rows[i].estatus) begin
          $error("directed row %0d kind/status exp %0d/%0d got %0d/%0d", i,
                 rows[i].ekind, rows[i].estatus, expected_q[expected_q.size()-1].kind,
                 expected_q[expected_q.size()-1].status);
          n_fail++;
        end
      end
    end

    // random: a small working set of lines so hits, conflicts and writebacks occur
    for (int i = 0; i < 8; i++) hot[i] = 24'($urandom);
    for (int i = 0; i < 40; i++) begin
      sel = $urandom_range(0, 19);
      f = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      if (sel == 0) send_req(FUNC_INVAL, 24'($urandom), 4'($urandom), '0, '0);
      else if (sel == 1) send_req(FUNC_FILL, 24'($urandom), 4'($urandom),
                                  {$urandom, $urandom}, {$urandom, $urandom});
      else if (sel == 2) begin
        // broken sequence: stray access inside a pending fill
        send_req(f, 24'($urandom), 4'($urandom), {$urandom, $urandom}, '0);
        send_req(f, 24'($urandom), 4'($urandom), {$urandom, $urandom}, '0);
        if (fill_busy) send_req(FUNC_INVAL, '0, '0, '0, '0);
      end else if (sel < 6) access_line(f, 24'($urandom), 4'($urandom_range(0, 15)));
      else access_line(f, {hot[$urandom_range(0, 7)][23:4], 4'($urandom)},
                       4'($urandom_range(1, 8)));
    end
    if (fill_busy) send_req(FUNC_INVAL, '0, '0, '0, '0);
    req.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("items sent: %0d, results checked: %0d, fill requests: %0d",
             n_items, n_results, n_miss_seen);
    $display("final totals: %0d hits, %0d misses", hits, misses);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
